FILE: hdl/subm_pkg.sv
// shared types and constants for the first substring match block
package subm_pkg;

    localparam int CAPACITY_DEFAULT = 64;
    localparam int BYTE_W           = 8;
    localparam int POS_W            = 6;

    // command codes carried in the operation field
    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_TEXT    = 2'd1,
        OP_PATTERN = 2'd2,
        OP_SEARCH  = 2'd3
    } op_t;

    typedef struct packed {
        op_t               operation;
        logic [BYTE_W-1:0] data_byte;
    } cmd_t;

    typedef struct packed {
        logic             match_found;
        logic [POS_W-1:0] match_position;
    } res_t;

    // sequencer to output stage: result ready this cycle
    typedef struct packed {
        logic done;
        res_t result;
    } seq_status_t;

endpackage

FILE: hdl/subm_ram.sv
// generic single write port ram with registered read
module subm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/subm_seq.sv
// command handling, store lengths and the iterative compare sequencer
module subm_seq
    import subm_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  cmd_t                        cmd_item,
    input  logic                        out_free,
    output seq_status_t                 status,
    output logic                        text_we,
    output logic                        pat_we,
    output logic [$clog2(CAPACITY)-1:0] waddr,
    output logic [BYTE_W-1:0]           wdata,
    output logic [$clog2(CAPACITY)-1:0] text_raddr,
    output logic [$clog2(CAPACITY)-1:0] pat_raddr,
    input  logic [BYTE_W-1:0]           text_rdata,
    input  logic [BYTE_W-1:0]           pat_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [LW-1:0]    tlen_reg, tlen_next;
    logic [LW-1:0]    plen_reg, plen_next;
    logic [AW-1:0]    start_reg, start_next;
    logic [AW-1:0]    k_reg, k_next;
    logic             found_reg, found_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic          accept;
    logic          text_room;
    logic          pat_room;
    logic          bytes_equal;
    logic          last_k;
    logic          next_start_fits;
    logic [LW:0]   next_end;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign text_room = (tlen_reg < LW'(CAPACITY));
    assign pat_room  = (plen_reg < LW'(CAPACITY));

    // store writes for append commands
    assign text_we = accept && (cmd_item.operation == OP_TEXT) && text_room;
    assign pat_we  = accept && (cmd_item.operation == OP_PATTERN) && pat_room;
    assign waddr   = (cmd_item.operation == OP_TEXT) ? tlen_reg[AW-1:0] : plen_reg[AW-1:0];
    assign wdata   = cmd_item.data_byte;

    // read addresses for the current comparison
    assign text_raddr = start_reg + k_reg;
    assign pat_raddr  = k_reg;

    // shared compare unit
    assign bytes_equal     = (text_rdata == pat_rdata);
    assign last_k          = ((LW'(k_reg) + LW'(1)) == plen_reg);
    assign next_end        = (LW+1)'(start_reg) + (LW+1)'(1) + (LW+1)'(plen_reg);
    assign next_start_fits = (next_end <= (LW+1)'(tlen_reg));

    // result handed to the output stage
    assign status.done                  = (state_reg == S_FINISH) && out_free;
    assign status.result.match_found    = found_reg;
    assign status.result.match_position = pos_reg;

    // next state and datapath
    always_comb
    begin
        state_next = state_reg;
        tlen_next  = tlen_reg;
        plen_next  = plen_reg;
        start_next = start_reg;
        k_next     = k_reg;
        found_next = found_reg;
        pos_next   = pos_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_item.operation)
                        OP_CLEAR:
                        begin
                            tlen_next = '0;
                            plen_next = '0;
                        end
                        OP_TEXT:
                        begin
                            if (text_room)
                            begin
                                tlen_next = tlen_reg + LW'(1);
                            end
                        end
                        OP_PATTERN:
                        begin
                            if (pat_room)
                            begin
                                plen_next = plen_reg + LW'(1);
                            end
                        end
                        OP_SEARCH:
                        begin
                            start_next = '0;
                            k_next     = '0;
                            found_next = 1'b0;
                            pos_next   = '0;
                            if (plen_reg == '0 || plen_reg > tlen_reg)
                            begin
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                priority if (bytes_equal && last_k)
                begin
                    found_next = 1'b1;
                    pos_next   = POS_W'(start_reg);
                    state_next = S_FINISH;
                end
                else if (bytes_equal)
                begin
                    k_next     = k_reg + AW'(1);
                    state_next = S_READ;
                end
                else if (next_start_fits)
                begin
                    start_next = start_reg + AW'(1);
                    k_next     = '0;
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tlen_reg  <= '0;
            plen_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tlen_reg  <= tlen_next;
            plen_reg  <= plen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        k_reg     <= k_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
    end

endmodule

FILE: hdl/first_substring_match.sv
// top level: first occurrence substring search over text and pattern stores
// sequencing: clear and append are accepted without a stall; a search runs each byte
// comparison through the single shared comparator (memory read then compare),
// then enters a finish state that waits for the output register to be free
// flow: one transaction at a time while a search runs; further commands stall
// reset: lengths cleared and no result pending; store contents are not reset
module first_substring_match
    import subm_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd_item,
    output logic res_valid,
    input  logic res_stall,
    output res_t res_item
);

    localparam int AW = $clog2(CAPACITY);

    seq_status_t       status;
    logic              out_free;
    logic              text_we;
    logic              pat_we;
    logic [AW-1:0]     waddr;
    logic [BYTE_W-1:0] wdata;
    logic [AW-1:0]     text_raddr;
    logic [AW-1:0]     pat_raddr;
    logic [BYTE_W-1:0] text_rdata;
    logic [BYTE_W-1:0] pat_rdata;
    logic              res_valid_reg;
    res_t              res_reg;

    subm_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_item   (cmd_item),
        .out_free   (out_free),
        .status     (status),
        .text_we    (text_we),
        .pat_we     (pat_we),
        .waddr      (waddr),
        .wdata      (wdata),
        .text_raddr (text_raddr),
        .pat_raddr  (pat_raddr),
        .text_rdata (text_rdata),
        .pat_rdata  (pat_rdata)
    );

    // text store
    subm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAPACITY)
    ) u_text_ram (
        .clk   (clk),
        .we    (text_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (text_raddr),
        .rdata (text_rdata)
    );

    // pattern store
    subm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAPACITY)
    ) u_pat_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

    // output register, free when empty or being taken
    assign out_free = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (status.done)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.done)
        begin
            res_reg <= status.result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

endmodule

FILE: tb/tb.sv
// self-checking testbench for the first substring match block
module tb;
    import subm_pkg::*;

    localparam int CAP          = CAPACITY_DEFAULT;
    localparam int ITEMS        = 700;
    localparam int QUIET_AT     = ITEMS - 100;
    localparam int HOLD_AT      = 200;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 50;

    // mirror of the text and pattern stores plus the queue of search results still owed
    class search_scoreboard;
        logic [BYTE_W-1:0] text_bytes [CAP];
        logic [BYTE_W-1:0] pattern_bytes [CAP];
        int                text_len;
        int                pattern_len;
        res_t              expected_q [$];
        int                errors;

        function new();
            text_len    = 0;
            pattern_len = 0;
            errors      = 0;
        endfunction

        // apply one accepted command transaction to the mirror
        function void note_command(cmd_t c);
            res_t r;
            bit   hit;
            int   s;
            int   k;
            r = '0;
            case (c.operation)
                OP_CLEAR:
                begin
                    text_len    = 0;
                    pattern_len = 0;
                end
                OP_TEXT:
                begin
                    // saturates once full
                    if (text_len < CAP)
                    begin
                        text_bytes[text_len] = c.data_byte;
                        text_len++;
                    end
                end
                OP_PATTERN:
                begin
                    if (pattern_len < CAP)
                    begin
                        pattern_bytes[pattern_len] = c.data_byte;
                        pattern_len++;
                    end
                end
                OP_SEARCH:
                begin
                    // naive scan, lowest start position first
                    if (pattern_len != 0 && pattern_len <= text_len)
                    begin
                        for (s = 0; s + pattern_len <= text_len && !r.match_found; s++)
                        begin
                            hit = 1'b1;
                            for (k = 0; k < pattern_len; k++)
                            begin
                                if (text_bytes[s + k] != pattern_bytes[k])
                                    hit = 1'b0;
                            end
                            if (hit)
                            begin
                                r.match_found    = 1'b1;
                                r.match_position = POS_W'(s);
                            end
                        end
                    end
                    expected_q.push_back(r);
                end
                default:
                begin
                end
            endcase
        endfunction

        // compare one result transaction with the oldest expectation
        function void check_result(res_t got);
            res_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual found=%0b position=%0d",
                         $time, got.match_found, got.match_position);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.match_found !== want.match_found)
                begin
                    $display("%0t: match_found expected %0b actual %0b",
                             $time, want.match_found, got.match_found);
                    errors++;
                end
                if (got.match_position !== want.match_position)
                begin
                    $display("%0t: match_position expected %0d actual %0d",
                             $time, want.match_position, got.match_position);
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd_item  = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res_item;

    search_scoreboard sb = new();
    int  sent_count = 0;
    bit  long_hold_done = 1'b0;

    first_substring_match #(
        .CAPACITY (CAP)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    always #5 clk = ~clk;

    // offer one command transaction, with an occasional idle burst first
    task automatic send_cmd(input op_t op, input logic [BYTE_W-1:0] b);
        cmd_t c;
        if (sent_count < QUIET_AT && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        c.operation = op;
        c.data_byte = b;
        cmd_valid <= 1'b1;
        cmd_item  <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sb.note_command(c);
        sent_count++;
    endtask

    // clear, load text and pattern, then search; pattern is usually a slice of the text
    task automatic run_search_sequence();
        logic [BYTE_W-1:0] text_buf [$];
        logic [BYTE_W-1:0] sym_a;
        logic [BYTE_W-1:0] sym_b;
        logic [BYTE_W-1:0] b;
        bit                fill;
        int                tlen;
        int                eff;
        int                plen;
        int                off;
        int                maxp;
        int                i;
        fill  = ($urandom_range(0, 11) == 0);
        sym_a = 8'($urandom);
        sym_b = 8'($urandom);
        tlen  = fill ? $urandom_range(CAP - 4, CAP + 4) : $urandom_range(0, 12);
        send_cmd(OP_CLEAR, 8'($urandom));
        // small alphabet on short texts gives many partial matches
        for (i = 0; i < tlen; i++)
        begin
            if (fill || $urandom_range(0, 3) == 0)
                b = 8'($urandom);
            else
                b = $urandom_range(0, 1) ? sym_a : sym_b;
            text_buf.push_back(b);
            send_cmd(OP_TEXT, b);
        end
        eff = (tlen > CAP) ? CAP : tlen;
        if (eff == 0 || $urandom_range(0, 4) == 0)
        begin
            // free-form pattern, may be empty, longer than the text or past capacity
            plen = fill ? $urandom_range(0, CAP + 3) : $urandom_range(0, 6);
            for (i = 0; i < plen; i++)
            begin
                if (fill)
                    send_cmd(OP_PATTERN, 8'($urandom));
                else
                    send_cmd(OP_PATTERN, $urandom_range(0, 1) ? sym_a : sym_b);
            end
        end
        else
        begin
            off  = $urandom_range(0, eff - 1);
            maxp = eff - off;
            if (maxp > (fill ? 8 : 5))
                maxp = fill ? 8 : 5;
            plen = $urandom_range(1, maxp);
            for (i = 0; i < plen; i++)
                send_cmd(OP_PATTERN, text_buf[off + i]);
        end
        send_cmd(OP_SEARCH, 8'($urandom));
        if ($urandom_range(0, 2) == 0)
        begin
            // grow the pattern by one byte and search again
            send_cmd(OP_PATTERN, $urandom_range(0, 1) ? sym_a : sym_b);
            send_cmd(OP_SEARCH, 8'($urandom));
        end
    endtask

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res_item);
    end

    // receiver back-pressure: random bursts, one long hold-off, none near the end
    initial
    begin : receiver
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && sent_count >= HOLD_AT)
            begin
                long_hold_done = 1'b1;
                res_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                res_stall <= 1'b0;
            end
            else if (sent_count < QUIET_AT && $urandom_range(0, 4) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // search with both stores empty
        send_cmd(OP_SEARCH, 8'h00);
        // text 00 ff 00 ff, overlapping candidates
        send_cmd(OP_TEXT, 8'h00);
        send_cmd(OP_TEXT, 8'hff);
        send_cmd(OP_TEXT, 8'h00);
        send_cmd(OP_TEXT, 8'hff);
        send_cmd(OP_PATTERN, 8'hff);
        send_cmd(OP_PATTERN, 8'h00);
        send_cmd(OP_SEARCH, 8'hff);
        send_cmd(OP_PATTERN, 8'hff);
        send_cmd(OP_SEARCH, 8'h00);
        // pattern as long as the text but different
        send_cmd(OP_PATTERN, 8'h00);
        send_cmd(OP_SEARCH, 8'h00);
        // pattern longer than the text
        send_cmd(OP_PATTERN, 8'haa);
        send_cmd(OP_SEARCH, 8'h55);
        // single byte match at position zero
        send_cmd(OP_CLEAR, 8'hff);
        send_cmd(OP_TEXT, 8'h5a);
        send_cmd(OP_PATTERN, 8'h5a);
        send_cmd(OP_SEARCH, 8'hff);
        // empty pattern against non-empty text
        send_cmd(OP_CLEAR, 8'h00);
        send_cmd(OP_TEXT, 8'h11);
        send_cmd(OP_SEARCH, 8'h00);

        // mostly well-formed sequences, some random noise transactions
        while (sent_count < ITEMS)
        begin
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(3, 12)) send_cmd(op_t'($urandom_range(0, 3)), 8'($urandom));
            else
                run_search_sequence();
        end
        cmd_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial
    begin : watchdog
        #10_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, sb.expected_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hdl/subm_pkg.sv
hdl/subm_ram.sv
hdl/subm_seq.sv
hdl/first_substring_match.sv
tb/tb.sv
